// ===== rtl/core/ljpf_pkg.sv =====
// Shared types, register map and reset values for the Lennard-Jones pair force block.
package ljpf_pkg;

  // Configuration register map, as word indexes of 64-bit registers.
  localparam int CfgAddrW = 5;
  localparam logic [1:0] RegSigmaSix = 2'd0;
  localparam logic [1:0] RegWellDepth = 2'd1;
  localparam logic [1:0] RegCutoffSq = 2'd2;

  localparam logic [47:0] SigmaSixReset = 48'd103039631;
  localparam logic [31:0] WellDepthReset = 32'd54142358;
  localparam logic [47:0] CutoffSqReset = 48'd19051479;

  // Q32.32 constants for one and one half.
  localparam logic [63:0] OneQ32 = 64'h0000_0001_0000_0000;
  localparam logic [63:0] HalfQ32 = 64'h0000_0000_8000_0000;

  typedef struct packed {
    logic [23:0] first_atom_id;
    logic [23:0] second_atom_id;
    logic signed [31:0] first_pos_x;
    logic signed [31:0] first_pos_y;
    logic signed [31:0] first_pos_z;
    logic signed [31:0] second_pos_x;
    logic signed [31:0] second_pos_y;
    logic signed [31:0] second_pos_z;
  } in_word_t;

  typedef struct packed {
    logic in_range;
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic signed [47:0] energy_term;
  } out_word_t;

  // Two's complement of a clamped magnitude, so saturation is symmetric.
  function automatic logic [47:0] apply_sign(input logic [46:0] mag, input logic neg);
    logic [47:0] m;
    m = {1'b0, mag};
    return neg ? (48'd0 - m) : m;
  endfunction

endpackage

// ===== rtl/core/ljpf_delay.sv =====
// Enabled shift-register delay line used to keep side data aligned with the datapath.
module ljpf_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) sr[k] <= '0;
    end else if (en) begin
      sr[0] <= d;
      for (int k = 1; k < N; k++) sr[k] <= sr[k-1];
    end
  end

  assign q = sr[N-1];

endmodule

// ===== rtl/core/ljpf_mul.sv =====
// Four-stage pipelined wide multiplier built from 32x32 partial products,
// with a final right shift and clamp to the output width.
module ljpf_mul #(
  parameter int WA = 64,
  parameter int WB = 64,
  parameter int SH = 0,
  parameter int OW = 64
) (
  input  logic          clk,
  input  logic          en,
  input  logic [WA-1:0] a,
  input  logic [WB-1:0] b,
  output logic [OW-1:0] p
);

  localparam int NA = (WA + 31) / 32;
  localparam int NB = (WB + 31) / 32;
  localparam int PW = 32 * (NA + NB);
  localparam int HW = PW - SH;

  logic [32*NA-1:0] ax;
  logic [32*NB-1:0] bx;
  logic [63:0]      pp [NA][NB];
  logic [PW-1:0]    row_next [NA];
  logic [PW-1:0]    row [NA];
  logic [PW-1:0]    prod_next;
  logic [PW-1:0]    prod;
  logic [HW-1:0]    hi;

  assign ax = (32*NA)'(a);
  assign bx = (32*NB)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= ax[32*i +: 32] * bx[32*j +: 32];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (PW'(pp[i][j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) row[i] <= row_next[i];
    end
  end

  always_comb begin
    prod_next = '0;
    for (int i = 0; i < NA; i++) prod_next = prod_next + row[i];
  end

  always_ff @(posedge clk) begin
    if (en) prod <= prod_next;
  end

  assign hi = prod[PW-1:SH];

  generate
    if (OW < HW) begin : g_clamp
      always_ff @(posedge clk) begin
        if (en) p <= (|hi[HW-1:OW]) ? '1 : hi[OW-1:0];
      end
    end else begin : g_plain
      always_ff @(posedge clk) begin
        if (en) p <= hi[OW-1:0];
      end
    end
  endgenerate

endmodule

// ===== rtl/core/ljpf_recip.sv =====
// Pipelined restoring divider forming floor((2^64-1)/r2), one quotient bit per stage.
module ljpf_recip #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_in,
  input  logic [63:0]   r2,
  input  logic [SW-1:0] side_in,
  output logic          valid_out,
  output logic [63:0]   recip,
  output logic [SW-1:0] side_out
);

  logic [63:0]   rem  [64];
  logic [63:0]   quo  [64];
  logic [63:0]   dvs  [64];
  logic [SW-1:0] side [64];
  logic [63:0]   vld;

  genvar k;
  generate
    for (k = 0; k < 64; k++) begin : g_stage
      logic [63:0]   rem_i;
      logic [63:0]   quo_i;
      logic [63:0]   dvs_i;
      logic [SW-1:0] side_i;
      logic          v_i;
      logic [64:0]   shifted;
      logic          ge;

      if (k == 0) begin : g_first
        assign rem_i  = '0;
        assign quo_i  = '0;
        assign dvs_i  = r2;
        assign side_i = side_in;
        assign v_i    = valid_in;
      end else begin : g_next
        assign rem_i  = rem[k-1];
        assign quo_i  = quo[k-1];
        assign dvs_i  = dvs[k-1];
        assign side_i = side[k-1];
        assign v_i    = vld[k-1];
      end

      // The dividend is all ones, so every shifted-in bit is a one.
      assign shifted = {rem_i, 1'b1};
      assign ge      = shifted >= {1'b0, dvs_i};

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k]  <= ge ? 64'(shifted - {1'b0, dvs_i}) : shifted[63:0];
          quo[k]  <= {quo_i[62:0], ge};
          dvs[k]  <= dvs_i;
          side[k] <= side_i;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en) begin
          vld[k] <= v_i;
        end
      end
    end
  endgenerate

  assign valid_out = vld[63];
  assign recip     = quo[63];
  assign side_out  = side[63];

endmodule

// ===== rtl/core/lennard_jones_pair_force.sv =====
// Top level of the Lennard-Jones 12-6 pair force and energy pipeline.
//
// Usage: one candidate pair (two atom ids and two Q16.16 positions) enters on
// the in channel as one word; the matching result word (in_range, the Q24.24
// force on atom i and the Q24.24 energy term) leaves on the out channel. A word
// moves at a rising edge where valid is high and stall is low.
// The pipeline takes a new word every cycle while in_stall is low. Each word
// passes through four front stages (difference, squares, sum, cutoff test),
// the 64-stage reciprocal divider that gives 1/r^2 one quotient bit per
// stage, and four-stage multipliers in series with a sign and output stage.
// Pairs that are skipped, beyond the cutoff or coincident still flow through
// and come out with in_range low and all other fields zero.
// When the receiver stalls while a result is held in the output register, the
// whole pipeline freezes and in_stall rises in the same cycle; nothing is lost
// or repeated. Reset clears every valid bit and loads the default register
// values. Registers are written through the APB port at byte addresses 0, 8
// and 16 and should only change while no pair is in flight.
module lennard_jones_pair_force (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  ljpf_pkg::in_word_t       in_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output ljpf_pkg::out_word_t      out_word,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ljpf_pkg::CfgAddrW-1:0] paddr,
  input  logic [63:0]              pwdata,
  output logic [63:0]              prdata,
  output logic                     pready
);

  import ljpf_pkg::*;

  localparam int SideW = 1 + 3 + 3 * 34;

  logic        adv;

  // Configuration registers.
  logic [47:0] sigma_six;
  logic [31:0] well_depth;
  logic [47:0] cutoff_squared;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_six      <= SigmaSixReset;
      well_depth     <= WellDepthReset;
      cutoff_squared <= CutoffSqReset;
    end else if (cfg_write) begin
      case (paddr[4:3])
        RegSigmaSix:  sigma_six      <= pwdata[47:0];
        RegWellDepth: well_depth     <= pwdata[31:0];
        RegCutoffSq:  cutoff_squared <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      RegSigmaSix:  prdata = {16'd0, sigma_six};
      RegWellDepth: prdata = {32'd0, well_depth};
      RegCutoffSq:  prdata = {16'd0, cutoff_squared};
      default:      prdata = '0;
    endcase
  end

  // The pipeline moves as one: it holds only while a result waits on a stall.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: coordinate differences as magnitude and sign.
  logic signed [32:0] dif [3];
  logic [31:0] mag1 [3];
  logic [2:0]  sgn1;
  logic        skip1;
  logic        v1;

  assign dif[0] = 33'(in_word.first_pos_x) - 33'(in_word.second_pos_x);
  assign dif[1] = 33'(in_word.first_pos_y) - 33'(in_word.second_pos_y);
  assign dif[2] = 33'(in_word.first_pos_z) - 33'(in_word.second_pos_z);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        mag1[k] <= dif[k][32] ? 32'(-dif[k]) : dif[k][31:0];
        sgn1[k] <= dif[k][32];
      end
      skip1 <= in_word.second_atom_id <= in_word.first_atom_id;
    end
  end

  // Stage 2: squares, and three times each magnitude for the final product.
  logic [63:0] sq2 [3];
  logic [33:0] m3_2 [3];
  logic [2:0]  sgn2;
  logic        skip2;
  logic        v2;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sq2[k]  <= mag1[k] * mag1[k];
        m3_2[k] <= 34'(mag1[k]) + (34'(mag1[k]) << 1);
      end
      sgn2  <= sgn1;
      skip2 <= skip1;
    end
  end

  // Stage 3: squared distance with two guard bits for overflow.
  logic [65:0] sum3;
  logic [33:0] m3_3 [3];
  logic [2:0]  sgn3;
  logic        skip3;
  logic        v3;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum3  <= 66'(sq2[0]) + 66'(sq2[1]) + 66'(sq2[2]);
      m3_3  <= m3_2;
      sgn3  <= sgn2;
      skip3 <= skip2;
    end
  end

  // Stage 4: decide whether the pair is dropped.
  logic [63:0] r2_4;
  logic [33:0] m3_4 [3];
  logic [2:0]  sgn4;
  logic        drop4;
  logic        v4;

  always_ff @(posedge clk) begin
    if (adv) begin
      r2_4  <= sum3[63:0];
      m3_4  <= m3_3;
      sgn4  <= sgn3;
      drop4 <= skip3 || (|sum3[65:64]) || (sum3[63:0] == 64'd0) ||
               (sum3[63:0] > {cutoff_squared, 16'd0});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Reciprocal of r^2 in Q32.32.
  logic [SideW-1:0] side4;
  logic [SideW-1:0] side_u;
  logic [63:0]      u0;
  logic             vu;

  assign side4 = {drop4, sgn4, m3_4[0], m3_4[1], m3_4[2]};

  ljpf_recip #(.SW(SideW)) u_recip (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .valid_in  (v4),
    .r2        (r2_4),
    .side_in   (side4),
    .valid_out (vu),
    .recip     (u0),
    .side_out  (side_u)
  );

  // Delayed copies of the reciprocal for the later products.
  logic [63:0] u_d4;
  logic [63:0] u_d8;
  logic [63:0] u_d17;

  ljpf_delay #(.W(64), .N(4)) u_dly_u4 (
    .clk(clk), .rst(rst), .en(adv), .d(u0), .q(u_d4)
  );
  ljpf_delay #(.W(64), .N(4)) u_dly_u8 (
    .clk(clk), .rst(rst), .en(adv), .d(u_d4), .q(u_d8)
  );
  ljpf_delay #(.W(64), .N(9)) u_dly_u17 (
    .clk(clk), .rst(rst), .en(adv), .d(u_d8), .q(u_d17)
  );

  // a = s6 / r^6, built as three saturating products with the reciprocal.
  logic [63:0] t1;
  logic [63:0] t2;
  logic [63:0] a12;

  ljpf_mul #(.WA(48), .WB(64), .SH(16), .OW(64)) u_mul_s (
    .clk(clk), .en(adv), .a(sigma_six), .b(u0), .p(t1)
  );
  ljpf_mul #(.WA(64), .WB(64), .SH(32), .OW(64)) u_mul_u2 (
    .clk(clk), .en(adv), .a(t1), .b(u_d4), .p(t2)
  );
  ljpf_mul #(.WA(64), .WB(64), .SH(32), .OW(64)) u_mul_u3 (
    .clk(clk), .en(adv), .a(t2), .b(u_d8), .p(a12)
  );

  // Distance of a from one (energy) and from one half (force).
  logic [63:0] a13;
  logic [63:0] m13;
  logic [63:0] w13;
  logic        nege13;
  logic        negf13;

  always_ff @(posedge clk) begin
    if (adv) begin
      a13    <= a12;
      nege13 <= a12 < OneQ32;
      negf13 <= a12 < HalfQ32;
      m13    <= (a12 < OneQ32) ? (OneQ32 - a12) : (a12 - OneQ32);
      w13    <= (a12 < HalfQ32) ? (HalfQ32 - a12) : (a12 - HalfQ32);
    end
  end

  logic [63:0] te17;
  logic [63:0] tf17;
  logic [63:0] tf21;
  logic [46:0] emag21;
  logic [95:0] y25;

  ljpf_mul #(.WA(64), .WB(64), .SH(32), .OW(64)) u_mul_e (
    .clk(clk), .en(adv), .a(a13), .b(m13), .p(te17)
  );
  ljpf_mul #(.WA(64), .WB(64), .SH(32), .OW(64)) u_mul_w (
    .clk(clk), .en(adv), .a(a13), .b(w13), .p(tf17)
  );
  ljpf_mul #(.WA(64), .WB(64), .SH(32), .OW(64)) u_mul_fu (
    .clk(clk), .en(adv), .a(tf17), .b(u_d17), .p(tf21)
  );
  ljpf_mul #(.WA(64), .WB(32), .SH(38), .OW(47)) u_mul_ee (
    .clk(clk), .en(adv), .a(te17), .b(well_depth), .p(emag21)
  );
  ljpf_mul #(.WA(64), .WB(32), .SH(0), .OW(96)) u_mul_fe (
    .clk(clk), .en(adv), .a(tf21), .b(well_depth), .p(y25)
  );

  // Side data lined up with the force products.
  logic [SideW-1:0] side25;
  logic [33:0]      m3_25 [3];
  logic [3:0]       ds29;
  logic [1:0]       neg29;
  logic [46:0]      emag29;
  logic             v29;

  ljpf_delay #(.W(SideW), .N(25)) u_dly_side (
    .clk(clk), .rst(rst), .en(adv), .d(side_u), .q(side25)
  );
  assign m3_25[0] = side25[101:68];
  assign m3_25[1] = side25[67:34];
  assign m3_25[2] = side25[33:0];

  ljpf_delay #(.W(4), .N(4)) u_dly_ds (
    .clk(clk), .rst(rst), .en(adv), .d(side25[SideW-1 -: 4]), .q(ds29)
  );
  ljpf_delay #(.W(2), .N(16)) u_dly_neg (
    .clk(clk), .rst(rst), .en(adv), .d({nege13, negf13}), .q(neg29)
  );
  ljpf_delay #(.W(47), .N(8)) u_dly_emag (
    .clk(clk), .rst(rst), .en(adv), .d(emag21), .q(emag29)
  );
  ljpf_delay #(.W(1), .N(29)) u_dly_v (
    .clk(clk), .rst(rst), .en(adv), .d(vu), .q(v29)
  );

  // Force magnitudes: (48 * y * |d|) >> 56, taken as (y * 3|d|) >> 52.
  logic [46:0] fmag29 [3];

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_force
      ljpf_mul #(.WA(96), .WB(34), .SH(52), .OW(47)) u_mul_f (
        .clk(clk), .en(adv), .a(y25), .b(m3_25[g]), .p(fmag29[g])
      );
    end
  endgenerate

  // Output register: signs applied, dropped pairs forced to zero.
  // The sign bits keep the order of sgn1, so bit 0 belongs to x.
  logic       drop29;
  logic [2:0] sgn29;

  assign drop29 = ds29[3];
  assign sgn29  = ds29[2:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word.in_range    <= !drop29;
      out_word.force_x     <= drop29 ? '0 : apply_sign(fmag29[0], sgn29[0] != neg29[0]);
      out_word.force_y     <= drop29 ? '0 : apply_sign(fmag29[1], sgn29[1] != neg29[0]);
      out_word.force_z     <= drop29 ? '0 : apply_sign(fmag29[2], sgn29[2] != neg29[0]);
      out_word.energy_term <= drop29 ? '0 : apply_sign(emag29, neg29[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v29;
    end
  end

  // A dropped pair carries no force or energy.
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.in_range |->
      out_word.force_x == '0 && out_word.force_y == '0 &&
      out_word.force_z == '0 && out_word.energy_term == '0)
    else $error("dropped pair has nonzero result");

  // Saturation is symmetric, so the most negative code never appears.
  a_sym_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      out_word.energy_term != 48'sh8000_0000_0000 &&
      out_word.force_x != 48'sh8000_0000_0000 &&
      out_word.force_y != 48'sh8000_0000_0000 &&
      out_word.force_z != 48'sh8000_0000_0000)
    else $error("result outside symmetric range");

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // While the held result waits, the pipeline refuses new pairs.
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("pair taken while result is stalled");

endmodule

// ===== test/lennard_jones_pair_force_test.sv =====
// Self-checking testbench for the Lennard-Jones pair force pipeline.
module lennard_jones_pair_force_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ljpf_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  // The drain pause outlasts the pipeline latency, which adds some margin.
  localparam int unsigned DrainCycles = 120;
  localparam logic [46:0] ForceClamp = 47'h7FFF_FFFF_FFFF;
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  // Shadow copies of the configuration registers.
  logic [47:0] sigma_six_q = SigmaSixReset;
  logic [31:0] well_depth_q = WellDepthReset;
  logic [47:0] cutoff_sq_q = CutoffSqReset;

  out_word_t pending_forces[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  // Receiver behavior: stall density in percent, and a forced long hold-off.
  int unsigned stall_pct = 0;
  logic hold_off = 1'b0;

  lennard_jones_pair_force dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung pipeline must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stall pattern, overridden by the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end
  end

  // Unsigned 64x64 product at full width.
  function automatic logic [127:0] wide_mul(input logic [63:0] a, input logic [63:0] b);
    return {64'd0, a} * {64'd0, b};
  endfunction

  // Floor shift right, clamped to 64 bits.
  function automatic logic [63:0] shift_clamp(input logic [127:0] p, input int s);
    logic [127:0] q;
    q = p >> s;
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  function automatic logic [47:0] signed_field(input logic [46:0] mag, input logic neg);
    logic [47:0] m;
    m = {1'b0, mag};
    return neg ? (48'd0 - m) : m;
  endfunction

  // Expected force and energy for one candidate pair under the current registers.
  function automatic out_word_t lj_pair_result(input in_word_t w);
    out_word_t r;
    logic signed [32:0] diff [3];
    logic [31:0] dmag [3];
    logic dneg [3];
    logic [66:0] dist_sq;
    logic [63:0] recip, t, a_q, m, wv;
    logic [127:0] y;
    logic [131:0] p3;
    logic [127:0] emag_w;
    logic [46:0] emag, fmag;
    logic nege, negf;
    logic [31:0] pi [3];
    logic [31:0] pj [3];
    r = '0;
    if (w.second_atom_id <= w.first_atom_id) return r;
    pi[0] = w.first_pos_x; pi[1] = w.first_pos_y; pi[2] = w.first_pos_z;
    pj[0] = w.second_pos_x; pj[1] = w.second_pos_y; pj[2] = w.second_pos_z;
    dist_sq = '0;
    for (int k = 0; k < 3; k++) begin
      diff[k] = $signed({pi[k][31], pi[k]}) - $signed({pj[k][31], pj[k]});
      dneg[k] = diff[k][32];
      dmag[k] = dneg[k] ? 32'(-diff[k]) : 32'(diff[k]);
      dist_sq = dist_sq + 67'({32'd0, dmag[k]} * {32'd0, dmag[k]});
    end
    // Sums at or above 2^64 count as beyond every cutoff.
    if (dist_sq[66:64] != 0) return r;
    if (dist_sq == 0 || dist_sq[63:0] > {cutoff_sq_q, 16'd0}) return r;
    recip = 64'hFFFF_FFFF_FFFF_FFFF / dist_sq[63:0];
    t = shift_clamp(wide_mul({16'd0, sigma_six_q}, recip), 16);
    t = shift_clamp(wide_mul(t, recip), 32);
    a_q = shift_clamp(wide_mul(t, recip), 32);

    nege = a_q < OneQ32;
    m = nege ? OneQ32 - a_q : a_q - OneQ32;
    t = shift_clamp(wide_mul(a_q, m), 32);
    emag_w = wide_mul(t, {32'd0, well_depth_q}) >> 38;
    emag = (emag_w > {81'd0, ForceClamp}) ? ForceClamp : emag_w[46:0];

    negf = a_q < HalfQ32;
    wv = negf ? HalfQ32 - a_q : a_q - HalfQ32;
    t = shift_clamp(wide_mul(a_q, wv), 32);
    t = shift_clamp(wide_mul(t, recip), 32);
    y = wide_mul(t, {32'd0, well_depth_q});

    r.in_range = 1'b1;
    for (int k = 0; k < 3; k++) begin
      // 48/2^56 equals 3/2^52.
      p3 = ({4'd0, y} * {100'd0, dmag[k]} * 132'd3) >> 52;
      fmag = (p3 > {85'd0, ForceClamp}) ? ForceClamp : p3[46:0];
      case (k)
        0: r.force_x = signed_field(fmag, dneg[k] != negf);
        1: r.force_y = signed_field(fmag, dneg[k] != negf);
        default: r.force_z = signed_field(fmag, dneg[k] != negf);
      endcase
    end
    r.energy_term = signed_field(emag, nege);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("mismatch %s at cycle %0d: got %h expected %h", what, cycle_count, got, want);
    mismatches++;
  endtask

  // Check each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_forces.size() == 0) begin
        report_mismatch("unexpected word", 48'(out_word.in_range), 48'd0);
      end else begin
        want = pending_forces.pop_front();
        if (out_word.in_range !== want.in_range)
          report_mismatch("in_range", 48'(out_word.in_range), 48'(want.in_range));
        if (out_word.force_x !== want.force_x)
          report_mismatch("force_x", out_word.force_x, want.force_x);
        if (out_word.force_y !== want.force_y)
          report_mismatch("force_y", out_word.force_y, want.force_y);
        if (out_word.force_z !== want.force_z)
          report_mismatch("force_z", out_word.force_z, want.force_z);
        if (out_word.energy_term !== want.energy_term)
          report_mismatch("energy_term", out_word.energy_term, want.energy_term);
      end
    end
  end

  // Offer one word and hold it until accepted. Valid stays high afterwards;
  // the caller lowers it when a gap follows.
  task automatic send_pair(input in_word_t w);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    pending_forces.push_back(lj_pair_result(w));
  endtask

  task automatic idle_gap(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Wait until every expected word has come back and the pipeline is empty.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // APB write: setup cycle then access cycle. The shadow copy changes with it.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CfgAddrW'(idx) << 3;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegSigmaSix: sigma_six_q = value[47:0];
      RegWellDepth: well_depth_q = value[31:0];
      default: cutoff_sq_q = value[47:0];
    endcase
  endtask

  task automatic set_registers(input logic [47:0] s6, input logic [31:0] eps,
                               input logic [47:0] cut);
    write_reg(RegSigmaSix, {16'd0, s6});
    write_reg(RegWellDepth, {32'd0, eps});
    write_reg(RegCutoffSq, {16'd0, cut});
  endtask

  function automatic in_word_t make_pair(input logic [23:0] id_i, input logic [23:0] id_j,
      input logic [31:0] xi, input logic [31:0] yi, input logic [31:0] zi,
      input logic [31:0] xj, input logic [31:0] yj, input logic [31:0] zj);
    in_word_t w;
    w.first_atom_id = id_i; w.second_atom_id = id_j;
    w.first_pos_x = xi; w.first_pos_y = yi; w.first_pos_z = zi;
    w.second_pos_x = xj; w.second_pos_y = yj; w.second_pos_z = zj;
    return w;
  endfunction

  // A pair whose ids are mostly in order and whose atoms sit within reach of
  // each other; a share of fully random words hits the skip and far paths.
  function automatic in_word_t random_pair(input int unsigned reach);
    in_word_t w;
    logic [255:0] rnd;
    logic [31:0] base [3];
    logic [31:0] offs [3];
    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = rnd[$bits(in_word_t)-1:0];
    if ($urandom_range(9) < 8) begin
      if (w.second_atom_id <= w.first_atom_id) begin
        w.first_atom_id = 24'($urandom_range(24'hFFFFFE));
        w.second_atom_id = w.first_atom_id + 24'd1 +
                           24'($urandom_range(24'hFFFFFE - w.first_atom_id));
      end
      for (int k = 0; k < 3; k++) begin
        base[k] = $urandom;
        offs[k] = $urandom_range(2 * reach) - reach;
      end
      w.second_pos_x = base[0]; w.first_pos_x = base[0] + offs[0];
      w.second_pos_y = base[1]; w.first_pos_y = base[1] + offs[1];
      w.second_pos_z = base[2]; w.first_pos_z = base[2] + offs[2];
    end
    return w;
  endfunction

  // Bursts of random length separated by random gaps, sometimes none.
  task automatic random_stream(input int unsigned count, input int unsigned reach);
    int unsigned burst;
    burst = 0;
    for (int unsigned n = 0; n < count; n++) begin
      send_pair(random_pair(reach));
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        idle_gap($urandom_range(3) == 0 ? 0 : $urandom_range(1, 8));
      end else begin
        burst--;
      end
    end
  endtask

  // Directed pairs under the reset register values.
  task automatic test_special_pairs;
    logic [31:0] u1;
    u1 = 32'h0001_0000;
    stall_pct = 0;
    // Equal and reversed ids are skipped; extreme ids in order are not.
    send_pair(make_pair(24'd5, 24'd5, 0, 0, 0, u1, 0, 0));
    send_pair(make_pair(24'hFFFFFF, 24'd0, 0, 0, 0, u1, 0, 0));
    send_pair(make_pair(24'd0, 24'hFFFFFF, u1, 0, 0, 0, 0, 0));
    send_pair(make_pair(24'hFFFFFE, 24'hFFFFFF, 0, u1, 0, 0, 0, 0));
    // Coincident atoms.
    send_pair(make_pair(24'd1, 24'd2, u1, u1, u1, u1, u1, u1));
    // Distance overflow with extreme positions on every axis.
    send_pair(make_pair(24'd1, 24'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_pair(make_pair(24'd1, 24'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    // Beyond the cutoff on one axis.
    send_pair(make_pair(24'd1, 24'd2, 32'h0020_0000, 0, 0, 0, 0, 0));
    // Near the well minimum, attractive and repulsive, with x and z positive and y negative.
    send_pair(make_pair(24'd3, 24'd9, 32'h0003_8000, 0, 0, 0, 0, 0));
    send_pair(make_pair(24'd3, 24'd9, 0, 32'hFFFC_8000, 0, 0, 0, 0));
    send_pair(make_pair(24'd3, 24'd9, 0, 0, 32'h0003_0000, 0, 0, 0));
    send_pair(make_pair(24'd3, 24'd9, 32'h0008_0000, 32'hFFF8_0000, 32'h0004_0000,
                        0, 0, 0));
    idle_gap(3);
    // Very close pairs drive the intermediates into saturation.
    send_pair(make_pair(24'd3, 24'd9, 32'd1, 0, 0, 0, 0, 0));
    send_pair(make_pair(24'd3, 24'd9, 32'd300, 32'hFFFF_FF00, 32'd7, 0, 0, 0));
    send_pair(make_pair(24'd3, 24'd9, 32'h0000_4000, 0, 0, 0, 0, 0));
    send_pair(make_pair(24'd3, 24'd9, 32'hFFFF_C000, 32'h0000_2000, 0, 0, 0, 0));
    drain();
  endtask

  // Register extremes, including a pair exactly on the cutoff.
  task automatic test_register_extremes;
    in_word_t on_edge, just_out;
    on_edge = make_pair(24'd10, 24'd11, 32'h0001_0000, 0, 0, 0, 0, 0);
    just_out = make_pair(24'd10, 24'd11, 32'h0001_0001, 0, 0, 0, 0, 0);
    stall_pct = 20;
    set_registers(48'd103039631, 32'd54142358, 48'h0001_0000);
    send_pair(on_edge);
    send_pair(just_out);
    drain();
    set_registers(Max48, 32'hFFFF_FFFF, Max48);
    random_stream(60, 32'h0010_0000);
    send_pair(make_pair(24'd0, 24'd1, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0));
    drain();
    set_registers(48'd0, 32'd0, 48'd0);
    send_pair(on_edge);
    send_pair(make_pair(24'd0, 24'd1, 32'd1, 0, 0, 0, 0, 0));
    random_stream(30, 32'h0000_0100);
    drain();
  endtask

  // Random pairs over several register settings and stall densities.
  task automatic test_random_settings;
    for (int phase = 0; phase < 6; phase++) begin
      stall_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 70);
      if (phase == 0)
        set_registers(SigmaSixReset, WellDepthReset, CutoffSqReset);
      else
        set_registers(48'({$urandom, $urandom}) & (Max48 >> $urandom_range(47)),
                      $urandom,
                      48'({$urandom, $urandom}) & (Max48 >> $urandom_range(47)));
      random_stream(260, (phase % 2 == 0) ? 32'h0012_0000 : 32'h0100_0000);
      drain();
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps going, so
  // the pipeline fills and in_stall rises.
  task automatic test_long_holdoff;
    set_registers(SigmaSixReset, WellDepthReset, CutoffSqReset);
    stall_pct = 5;
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int n = 0; n < 200; n++) send_pair(random_pair(32'h0012_0000));
      end
    join
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_pairs();
    test_register_extremes();
    test_random_settings();
    test_long_holdoff();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ljpf_pkg.sv
rtl/core/ljpf_delay.sv
rtl/core/ljpf_mul.sv
rtl/core/ljpf_recip.sv
rtl/core/lennard_jones_pair_force.sv
test/lennard_jones_pair_force_test.sv
